>>> src/websocket_frame_unmasker_defines.svh
// ----------------------------------------------------------------------------
// websocket_frame_unmasker_defines.svh
// Assertion macros used by the checker.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define WSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/wsu_pkg.sv
// ----------------------------------------------------------------------------
// wsu_pkg
// Types and constants for the websocket frame unmasker.
// ----------------------------------------------------------------------------
`default_nettype none

package wsu_pkg;

    localparam int unsigned MAX_BUFFER_BYTES = 2048;
    localparam int unsigned BYTES_SEEN_W     = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int unsigned MIN_FRAME_BYTES  = 6;

    localparam int unsigned LEN_W  = 64;
    localparam int unsigned LEFT_W = 4;

    // header fields
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [LEFT_W-1:0] EXT16_BYTES = LEFT_W'(2);
    localparam logic [LEFT_W-1:0] EXT64_BYTES = LEFT_W'(8);

    // final status codes
    localparam logic [1:0] ST_COMPLETE   = 2'd0;
    localparam logic [1:0] ST_CLOSE      = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASK,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic       present;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       frame_end;
        logic [1:0] status;
    } result_t;

endpackage

`default_nettype wire

>>> src/wsu_parser.sv
// ----------------------------------------------------------------------------
// wsu_parser
// Header parse state, mask key store and payload unmasking for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wsu_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       rx_byte,
    input  wire logic             buffer_end,
    output wsu_pkg::result_t      result
);

    wsu_pkg::phase_t                        phase_reg, phase_next;
    logic [wsu_pkg::BYTES_SEEN_W-1:0]       seen_reg, seen_next;
    logic [wsu_pkg::LEN_W-1:0]              len_reg, len_next;   // length, then bytes left
    logic [wsu_pkg::LEFT_W-1:0]             left_reg, left_next;
    logic [1:0]                             idx_reg, idx_next;
    logic                                   masked_reg, masked_next;
    logic                                   close_reg, close_next;
    logic [7:0]                             key_reg [4];
    logic                                   key_we;
    logic [wsu_pkg::LEN_W-1:0]              len_shift;
    logic [7:0]                             data;
    logic                                   valid;
    logic [1:0]                             status;

    assign len_shift = {len_reg[wsu_pkg::LEN_W-9:0], rx_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        seen_next   = seen_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        idx_next    = idx_reg;
        masked_next = masked_reg;
        close_next  = close_reg;
        key_we      = 1'b0;
        data        = 8'h00;
        valid       = 1'b0;

        if (seen_reg < wsu_pkg::BYTES_SEEN_W'(wsu_pkg::MAX_BUFFER_BYTES))
        begin
            seen_next = seen_reg + 1'b1;
            case (phase_reg)
                wsu_pkg::PH_HDR0:
                begin
                    close_next = (rx_byte[3:0] == wsu_pkg::OPC_CLOSE);
                    phase_next = wsu_pkg::PH_HDR1;
                end
                wsu_pkg::PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    if (rx_byte[6:0] == wsu_pkg::LEN_EXT16)
                    begin
                        len_next   = '0;
                        left_next  = wsu_pkg::EXT16_BYTES;
                        phase_next = wsu_pkg::PH_EXTLEN;
                    end
                    else if (rx_byte[6:0] == wsu_pkg::LEN_EXT64)
                    begin
                        len_next   = '0;
                        left_next  = wsu_pkg::EXT64_BYTES;
                        phase_next = wsu_pkg::PH_EXTLEN;
                    end
                    else
                    begin
                        len_next = wsu_pkg::LEN_W'(rx_byte[6:0]);
                        if (rx_byte[7])
                        begin
                            idx_next   = 2'd0;
                            phase_next = wsu_pkg::PH_MASK;
                        end
                        else if (rx_byte[6:0] == 7'd0)
                            phase_next = wsu_pkg::PH_DONE;
                        else
                            phase_next = wsu_pkg::PH_PAYLOAD;
                    end
                end
                wsu_pkg::PH_EXTLEN:
                begin
                    len_next  = len_shift;
                    left_next = left_reg - 1'b1;
                    if (left_reg == wsu_pkg::LEFT_W'(1))
                    begin
                        if (masked_reg)
                        begin
                            idx_next   = 2'd0;
                            phase_next = wsu_pkg::PH_MASK;
                        end
                        else if (len_shift == '0)
                            phase_next = wsu_pkg::PH_DONE;
                        else
                            phase_next = wsu_pkg::PH_PAYLOAD;
                    end
                end
                wsu_pkg::PH_MASK:
                begin
                    key_we   = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    // key complete: index wraps to 0, which is also payload byte 0
                    if (idx_reg == 2'd3)
                        phase_next = (len_reg == '0) ? wsu_pkg::PH_DONE
                                                     : wsu_pkg::PH_PAYLOAD;
                end
                wsu_pkg::PH_PAYLOAD:
                begin
                    valid    = !close_reg;
                    data     = masked_reg ? (rx_byte ^ key_reg[idx_reg]) : rx_byte;
                    idx_next = idx_reg + 1'b1;
                    len_next = len_reg - 1'b1;
                    if (len_reg == wsu_pkg::LEN_W'(1))
                        phase_next = wsu_pkg::PH_DONE;
                end
                default:
                begin
                end
            endcase
        end

        if (seen_next < wsu_pkg::BYTES_SEEN_W'(wsu_pkg::MIN_FRAME_BYTES))
            status = wsu_pkg::ST_INCOMPLETE;
        else if (close_next)
            status = wsu_pkg::ST_CLOSE;
        else if (phase_next == wsu_pkg::PH_DONE)
            status = wsu_pkg::ST_COMPLETE;
        else
            status = wsu_pkg::ST_INCOMPLETE;

        result.present    = valid || buffer_end;
        result.data_byte  = valid ? data : 8'h00;
        result.byte_valid = valid;
        result.frame_end  = buffer_end;
        result.status     = buffer_end ? status : wsu_pkg::ST_COMPLETE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsu_pkg::PH_HDR0;
            seen_reg   <= '0;
            len_reg    <= '0;
            left_reg   <= '0;
            idx_reg    <= 2'd0;
            masked_reg <= 1'b0;
            close_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (buffer_end)
            begin
                // buffer done: start over for the next one
                phase_reg  <= wsu_pkg::PH_HDR0;
                seen_reg   <= '0;
                len_reg    <= '0;
                left_reg   <= '0;
                idx_reg    <= 2'd0;
                masked_reg <= 1'b0;
                close_reg  <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                seen_reg   <= seen_next;
                len_reg    <= len_next;
                left_reg   <= left_next;
                idx_reg    <= idx_next;
                masked_reg <= masked_next;
                close_reg  <= close_next;
            end
        end
    end

    // key store, written before use within each frame
    always_ff @(posedge clk)
    begin
        if (step && key_we)
            key_reg[idx_reg] <= rx_byte;
    end

endmodule

`default_nettype wire

>>> src/websocket_frame_unmasker.sv
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Parses the first frame header of a receive buffer and unmasks its payload.
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata            | tuser                  | tlast
//  ----------+-----+------------------+------------------------+------------
//  s_axis    | in  | [7:0] rx_byte    | -                      | buffer_end
//  m_axis    | out | [7:0] data_byte  | [0] byte_valid,        | frame_end
//            |     |                  | [2:1] status           |
//
//  One byte per cycle while m_axis does not stall. Each request goes into an
//  input register, is parsed and unmasked by one pass of logic in the parser,
//  and the result lands in the output register.
//  A request that yields no result (header, extended length, mask key,
//  trailing bytes) retires without touching the output register.
//  A stalled m_axis holds the input register only when it has a result to
//  pass on; nothing is dropped. Reset clears all parse state but the mask key at once.
//
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_unmasker (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,    // [7:0] rx_byte
    input  wire logic       s_axis_tlast,    // buffer_end

    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,    // [7:0] data_byte
    output logic [2:0]      m_axis_tuser,    // [0] byte_valid, [2:1] status
    output logic            m_axis_tlast     // frame_end
);

    // input register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;

    // output register
    logic             out_valid_reg;
    wsu_pkg::result_t out_reg;

    wsu_pkg::result_t res;
    logic             advance;

    // The held request moves on when it has no result, or the output
    // register is free or being drained this cycle.
    assign advance       = in_valid_reg &&
                           (!res.present || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    wsu_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .rx_byte    (in_byte_reg),
        .buffer_end (in_last_reg),
        .result     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res.present)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.present)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.data_byte;
    assign m_axis_tuser  = {out_reg.status, out_reg.byte_valid};
    assign m_axis_tlast  = out_reg.frame_end;

endmodule

`default_nettype wire

>>> src/wsu_checker.sv
// ----------------------------------------------------------------------------
// wsu_checker
// Port-level checks on the unmasker's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "websocket_frame_unmasker_defines.svh"

module wsu_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [2:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    `WSU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
                     "result dropped while stalled")
    `WSU_ASSERT_NOW(a_empty_is_end, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast,
                    "result with no byte and no frame end")
    `WSU_ASSERT_NOW(a_status_only_at_end, m_axis_tvalid && !m_axis_tlast,
                    m_axis_tuser[2:1] == wsu_pkg::ST_COMPLETE,
                    "status set before frame end")
    `WSU_ASSERT_NOW(a_empty_data_zero, m_axis_tvalid && !m_axis_tuser[0],
                    m_axis_tdata == 8'h00, "data set without a payload byte")
    `WSU_ASSERT_NOW(a_status_code, m_axis_tvalid,
                    m_axis_tuser[2:1] <= wsu_pkg::ST_INCOMPLETE, "unused status code")

endmodule

bind websocket_frame_unmasker wsu_checker u_wsu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
